FILE: hdl/lphm_pkg.sv
// Shared types and constants for the linear probing hash map.
`timescale 1ns / 1ps

package lphm_pkg;

  // Table depth is a power of two, so the home slot is the low key bits.
  localparam int IDX_W      = 10;
  localparam int DEPTH      = 1 << IDX_W;
  localparam int USED_W     = IDX_W + 1;
  localparam int LOAD_LIMIT = DEPTH * 2 / 3;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  localparam logic [1:0] SLOT_EMPTY  = 2'd0;
  localparam logic [1:0] SLOT_FILLED = 2'd1;
  localparam logic [1:0] SLOT_TOMB   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [63:0] value_out;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [63:0] key;
    logic [63:0] value;
  } slot_entry_t;

  typedef struct packed {
    logic hit;
    logic tomb;
    logic empty;
  } probe_class_t;

endpackage

FILE: hdl/lphm_slot_ram.sv
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps

module lphm_slot_ram
  import lphm_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_entry_t      wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_entry_t      rd_data
);

  slot_entry_t mem [DEPTH];
  slot_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/lphm_probe_unit.sv
// Shared slot classifier: key compare and slot state decode for one probe.
`timescale 1ns / 1ps

module lphm_probe_unit
  import lphm_pkg::*;
(
  input  slot_entry_t  entry,
  input  logic [63:0]  key,
  output probe_class_t cls
);

  logic key_eq;

  assign key_eq    = (entry.key == key);
  assign cls.hit   = (entry.state == SLOT_FILLED) && key_eq;
  assign cls.tomb  = (entry.state == SLOT_TOMB);
  assign cls.empty = (entry.state != SLOT_FILLED) && (entry.state != SLOT_TOMB);

endmodule

FILE: hdl/linear_probe_hash_map_core.sv
// Each accepted item walks its probe, then holds its result in a response state until the output
// register is free; no new item is accepted until then. The probe walks one slot a cycle
// through the single read port of the slot memory and the shared key comparator.
// Kind 3 items skip the probe and go straight to the response state.
// Reset (rst_n low, synchronous) starts a clearing pass that marks every slot
// empty; no item is accepted until it ends.
`timescale 1ns / 1ps

module linear_probe_hash_map_core
  import lphm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // Sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_PROBE = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             tomb_seen_r, tomb_seen_nxt;
  logic [IDX_W-1:0] tomb_pos_r, tomb_pos_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  in_item_t         item_r, item_nxt;
  out_item_t        res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  slot_entry_t      wr_data, rd_data;
  probe_class_t     cls;

  logic             tomb_any;
  logic [IDX_W-1:0] tomb_at;
  logic [IDX_W-1:0] next_pos;
  logic             last_probe;
  logic             out_free;

  lphm_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lphm_probe_unit u_probe (
    .entry (rd_data),
    .key   (item_r.key),
    .cls   (cls)
  );

  // First tombstone on the probe, counting the slot under test right now
  assign tomb_any   = tomb_seen_r | cls.tomb;
  assign tomb_at    = tomb_seen_r ? tomb_pos_r : pos_r;
  // Power-of-two depth: the increment wraps on its own
  assign next_pos   = pos_r + 1'b1;
  assign last_probe = (cnt_r == {IDX_W{1'b1}});
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    tomb_seen_nxt = tomb_seen_r;
    tomb_pos_nxt  = tomb_pos_r;
    used_nxt      = used_r;
    item_nxt      = item_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    // Drop the output item once it is taken
    out_valid_nxt = out_valid_r && out_stall;
    rd_en         = 1'b0;
    rd_addr       = pos_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = '{state: SLOT_FILLED, key: item_r.key, value: item_r.value};

    case (state_r)
      S_CLEAR: begin
        // Sweep every slot to empty after reset
        wr_en         = 1'b1;
        wr_addr       = clr_r;
        wr_data       = '{state: SLOT_EMPTY, key: 64'd0, value: 64'd0};
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == {IDX_W{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.kind != KIND_SET && in_data.kind != KIND_REMOVE &&
              in_data.kind != KIND_LOOKUP) begin
            // Unused kind: no probe, all-zero result
            res_nxt   = '{found: 1'b0, value_out: 64'd0, status: STATUS_OK};
            state_nxt = S_RESP;
          end else begin
            // Start the probe at the home slot
            rd_en         = 1'b1;
            rd_addr       = in_data.key[IDX_W-1:0];
            pos_nxt       = in_data.key[IDX_W-1:0];
            cnt_nxt       = '0;
            tomb_seen_nxt = 1'b0;
            state_nxt     = S_PROBE;
          end
        end
      end

      S_PROBE: begin
        if (cls.hit || cls.empty || last_probe) begin
          // Probe over: commit the operation and form the result
          res_nxt   = '{found: cls.hit, value_out: 64'd0, status: STATUS_OK};
          state_nxt = S_RESP;
          case (item_r.kind)
            KIND_SET: begin
              if (cls.hit) begin
                wr_en = 1'b1;
              end else if (tomb_any) begin
                // Reuse the first tombstone; load count holds
                wr_en   = 1'b1;
                wr_addr = tomb_at;
              end else if (cls.empty && (used_r < USED_W'(LOAD_LIMIT))) begin
                wr_en    = 1'b1;
                used_nxt = used_r + 1'b1;
              end else begin
                res_nxt.status = STATUS_FULL;
              end
            end
            KIND_REMOVE: begin
              if (cls.hit) begin
                wr_en   = 1'b1;
                wr_data = '{state: SLOT_TOMB, key: rd_data.key, value: rd_data.value};
              end
            end
            KIND_LOOKUP: begin
              if (cls.hit) begin
                res_nxt.value_out = rd_data.value;
              end else begin
                res_nxt.status = STATUS_ABSENT;
              end
            end
            default: begin
              res_nxt = res_r;
            end
          endcase
        end else begin
          // Advance to the next slot, note the first tombstone
          rd_en   = 1'b1;
          rd_addr = next_pos;
          pos_nxt = next_pos;
          cnt_nxt = cnt_r + 1'b1;
          if (cls.tomb && !tomb_seen_r) begin
            tomb_seen_nxt = 1'b1;
            tomb_pos_nxt  = pos_r;
          end
        end
      end

      S_RESP: begin
        // Hold the result until the output register is free
        if (out_free) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and probe bookkeeping: no reset needed
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    tomb_seen_r <= tomb_seen_nxt;
    tomb_pos_r  <= tomb_pos_nxt;
    item_r      <= item_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_CLEAR || state_r == S_PROBE))
    else $error("slot write outside clear or probe");

  a_load_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_W'(LOAD_LIMIT))
    else $error("load count above limit");

  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RESP)
    else $error("output item posted outside response state");

  a_probe_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE && state_nxt == S_PROBE) |=> (pos_r == $past(pos_r) + 1'b1))
    else $error("probe did not advance one slot");
`endif

endmodule

FILE: dv/linear_probe_hash_map_core_checker.sv
// Reply checker for the hash map core: shadow table, expected reply queue, compare.
`timescale 1ns / 1ps

module linear_probe_hash_map_core_checker
  import lphm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  in_item_t        in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  out_item_t       out_data,
  output int unsigned     mismatches,
  output int unsigned     outstanding,
  output int unsigned     replies_checked,
  output int unsigned     full_refusals
);

  // Shadow copy of the table contents.
  logic [63:0]    shadow_key  [DEPTH];
  logic [63:0]    shadow_val  [DEPTH];
  logic           shadow_live [DEPTH];
  logic           shadow_tomb [DEPTH];
  int unsigned    shadow_used = 0;

  out_item_t      pending_replies [$];
  int unsigned    err_total     = 0;
  int unsigned    reply_total   = 0;
  int unsigned    refused_total = 0;

  // Walk from the home slot: skip tombstones and other keys, stop on a hit or an empty slot.
  function automatic bit locate_key(input logic [63:0] key, output int hit,
                                    output int tomb, output int empty);
    int pos;
    pos   = int'(key[IDX_W-1:0]);
    hit   = DEPTH;
    tomb  = DEPTH;
    empty = DEPTH;
    for (int n = 0; n < DEPTH; n++) begin
      if (shadow_tomb[pos]) begin
        if (tomb == DEPTH) tomb = pos;
      end else if (shadow_live[pos]) begin
        if (shadow_key[pos] == key) begin
          hit = pos;
          return 1'b1;
        end
      end else begin
        empty = pos;
        return 1'b0;
      end
      pos = (pos + 1) % DEPTH;
    end
    return 1'b0;
  endfunction

  // Apply one operation to the shadow table and return the reply it should give.
  function automatic out_item_t apply_map_op(input in_item_t op);
    out_item_t reply;
    bit        present;
    int        hit;
    int        tomb;
    int        empty;
    int        dst;
    reply.found     = 1'b0;
    reply.value_out = '0;
    reply.status    = STATUS_OK;
    if (op.kind == KIND_SET || op.kind == KIND_REMOVE || op.kind == KIND_LOOKUP) begin
      present = locate_key(op.key, hit, tomb, empty);
      case (op.kind)
        KIND_SET: begin
          if (present) begin
            shadow_val[hit] = op.value;
            reply.found     = 1'b1;
          end else begin
            dst = DEPTH;
            if (tomb < DEPTH) begin
              dst = tomb;
            end else if (empty < DEPTH && shadow_used < LOAD_LIMIT) begin
              dst = empty;
              shadow_used++;
            end
            if (dst < DEPTH) begin
              shadow_live[dst] = 1'b1;
              shadow_tomb[dst] = 1'b0;
              shadow_key[dst]  = op.key;
              shadow_val[dst]  = op.value;
            end else begin
              reply.status = STATUS_FULL;
            end
          end
        end
        KIND_REMOVE: begin
          if (present) begin
            shadow_live[hit] = 1'b0;
            shadow_tomb[hit] = 1'b1;
            reply.found      = 1'b1;
          end
        end
        default: begin
          if (present) begin
            reply.found     = 1'b1;
            reply.value_out = shadow_val[hit];
          end else begin
            reply.status = STATUS_ABSENT;
          end
        end
      endcase
    end
    return reply;
  endfunction

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        shadow_live[i] = 1'b0;
        shadow_tomb[i] = 1'b0;
      end
      shadow_used = 0;
      pending_replies.delete();
    end else begin
      // Check the reply first: an item accepted at this edge cannot have replied yet.
      if (out_valid && !out_stall) begin
        got = out_data;
        reply_total++;
        if (pending_replies.size() == 0) begin
          err_total++;
          if (err_total <= 10)
            $display("MISMATCH @%0t: reply with none expected: found=%0b value_out=%h status=%0d",
                     $realtime, got.found, got.value_out, got.status);
        end else begin
          want = pending_replies.pop_front();
          if (want.status == STATUS_FULL) refused_total++;
          if (got.found !== want.found || got.value_out !== want.value_out ||
              got.status !== want.status) begin
            err_total++;
            if (err_total <= 10) begin
              $display("MISMATCH @%0t: found exp=%0b got=%0b, status exp=%0d got=%0d",
                       $realtime, want.found, got.found, want.status, got.status);
              $display("          value_out exp=%h got=%h", want.value_out, got.value_out);
            end
          end
        end
      end
      if (in_valid && !in_stall)
        pending_replies.push_back(apply_map_op(in_data));
    end
    mismatches      <= err_total;
    outstanding     <= pending_replies.size();
    replies_checked <= reply_total;
    full_refusals   <= refused_total;
  end

endmodule

FILE: dv/linear_probe_hash_map_core_tb.sv
// Testbench top for the hash map core: clock, reset, item stimulus, reply stalls, verdict.
`timescale 1ns / 1ps

module linear_probe_hash_map_core_tb
  import lphm_pkg::*;
();

  // Kind 3 has no name in the package; the core must treat it as a no-op.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int POOL_SIZE    = 48;
  localparam int MIXED_OPS    = 200;
  localparam int FILL_MAX     = 220;
  localparam int FILL_REFUSED = 24;
  localparam int LATE_OPS     = 60;
  // Longest probe plus pipeline overhead, with margin.
  localparam int DRAIN_CYCLES = DEPTH + 16;
  // Worst case: ~500 items, each a full-depth probe plus gaps and stalls, plus the clearing
  // pass; the limit takes about 10x that.
  localparam int CYCLE_LIMIT  = 6_000_000;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned replies_checked;
  int unsigned full_refusals;

  // Sender burst state and receiver stall pattern state.
  int          burst_left = 0;
  int          stall_span = 0;
  int          stall_mode = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;

  // Keys whose home slots crowd the top and bottom of the table, so probes
  // collide, run long and wrap around.
  logic [63:0] key_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  linear_probe_hash_map_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  linear_probe_hash_map_core_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .replies_checked (replies_checked),
    .full_refusals   (full_refusals)
  );

  // Receiver: hold a stall mode (none, light, heavy) for a random span, then pick another.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_span <= 0;
      stall_mode <= 0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_span <= $urandom_range(16, 96);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Watchdog: end the run if the core stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies outstanding", cycle_count, outstanding);
      $display("linear_probe_hash_map_core_tb failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Mostly random values, with the all-zero and all-one extremes now and then.
  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return rand_word();
    endcase
  endfunction

  function automatic logic [63:0] pool_key();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Drive one item and hold it until accepted. Between bursts, drop valid
  // for a random gap; inside a burst, keep valid high and just change the payload.
  task automatic send_op(input logic [1:0] kind, input logic [63:0] key,
                         input logic [63:0] value);
    in_item_t op;
    int       gap;
    op.kind  = kind;
    op.key   = key;
    op.value = value;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  initial begin : stimulus
    int          r;
    int          fill_count;
    logic [63:0] k;

    // Home slots span DEPTH-20 .. DEPTH+11, wrapping past the last slot.
    for (int i = 0; i < POOL_SIZE; i++) begin
      k = rand_word();
      k[IDX_W-1:0] = IDX_W'((DEPTH - 20 + $urandom_range(0, 31)) % DEPTH);
      key_pool[i] = k;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table miss, collisions at home slot 0, tombstone handling,
    // wraparound at the end of the table, and the unused kind.
    send_op(KIND_LOOKUP, 64'd0, rand_word());            // miss on the empty table
    send_op(KIND_SET,    64'd0, '1);                     // insert, all-ones value
    send_op(KIND_SET,    64'(DEPTH), '0);                // collide, land one slot on
    send_op(KIND_SET,    64'(2 * DEPTH), rand_word());   // collide twice
    send_op(KIND_LOOKUP, 64'd0, rand_word());            // hit at home slot
    send_op(KIND_REMOVE, 64'(DEPTH), rand_word());       // leave a tombstone in the chain
    send_op(KIND_LOOKUP, 64'(2 * DEPTH), rand_word());   // hit past the tombstone
    send_op(KIND_SET,    64'(2 * DEPTH), rand_word());   // update past it, no duplicate
    send_op(KIND_LOOKUP, 64'(2 * DEPTH), rand_word());
    send_op(KIND_LOOKUP, 64'(DEPTH), rand_word());       // removed key is absent
    send_op(KIND_SET,    64'(3 * DEPTH), rand_word());   // reuse the tombstone
    send_op(KIND_REMOVE, 64'(DEPTH), rand_word());       // remove of an absent key
    send_op(KIND_SET,    '1, rand_word());               // all-ones key, last slot
    send_op(KIND_SET,    64'(DEPTH - 1), rand_word());   // wraps to the front
    send_op(KIND_LOOKUP, 64'(DEPTH - 1), rand_word());
    send_op(KIND_UNUSED, '1, '1);
    send_op(KIND_REMOVE, '1, rand_word());
    send_op(KIND_LOOKUP, '1, rand_word());
    send_op(KIND_LOOKUP, 64'(DEPTH - 1), rand_word());   // wrap past a tombstone
    send_op(KIND_UNUSED, '0, '0);

    // Mixed traffic on the crowded pool: churn of inserts, removes and lookups.
    repeat (MIXED_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 35)       send_op(KIND_SET,    pool_key(), rand_value());
      else if (r < 55)  send_op(KIND_REMOVE, pool_key(), rand_word());
      else if (r < 85)  send_op(KIND_LOOKUP, pool_key(), rand_word());
      else if (r < 90)  send_op(KIND_UNUSED, rand_word(), rand_word());
      else              send_op(2'($urandom_range(0, 2)), rand_word(), rand_value());
    end

    // Fill with fresh keys to raise the load; stop early once FILL_REFUSED inserts are refused.
    fill_count = 0;
    while (fill_count < FILL_MAX && full_refusals < FILL_REFUSED) begin
      if ($urandom_range(0, 9) == 0) send_op(KIND_LOOKUP, pool_key(), rand_word());
      else                           send_op(KIND_SET, rand_word(), rand_value());
      fill_count++;
    end

    // After the fill: removes leave tombstones that later inserts may reuse.
    repeat (LATE_OPS) begin
      r = $urandom_range(0, 99);
      if (r < 30)       send_op(KIND_REMOVE, pool_key(), rand_word());
      else if (r < 60)  send_op(KIND_SET,    pool_key(), rand_value());
      else if (r < 85)  send_op(KIND_LOOKUP, pool_key(), rand_word());
      else if (r < 95)  send_op(KIND_SET,    rand_word(), rand_value());
      else              send_op(KIND_UNUSED, rand_word(), rand_word());
    end

    in_valid <= 1'b0;

    // Drain: wait for every reply, then give the core time to show any extra one.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items (directed, pool churn, fill with fresh keys, late churn).",
             items_sent);
    $display("Compared %0d replies, %0d refused inserts, %0d mismatches.",
             replies_checked, full_refusals, mismatches);
    if (mismatches == 0) begin
      $display("linear_probe_hash_map_core_tb passed");
    end else begin
      $display("linear_probe_hash_map_core_tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lphm_pkg.sv
hdl/lphm_slot_ram.sv
hdl/lphm_probe_unit.sv
hdl/linear_probe_hash_map_core.sv
dv/linear_probe_hash_map_core_checker.sv
dv/linear_probe_hash_map_core_tb.sv
